/* hw/rtl/lcg_rng_pkg.sv */
`default_nettype none

package lcg_rng_pkg;

  localparam int unsigned SEED_W    = 31;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned SPAN_W    = WORD_W + 1;
  localparam int unsigned DIV_STEPS = SEED_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [SEED_W-1:0] LCG_MUL = 31'd1103515245;
  localparam logic [SEED_W-1:0] LCG_INC = 31'd12345;

  typedef enum logic [1:0] {
    MODE_RAW   = 2'd0,
    MODE_RANGE = 2'd1,
    MODE_MOD   = 2'd2,
    MODE_LOAD  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAW,
    ST_DIVIDE,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic capture;
    logic advance;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic need_div;
  } sts_t;

endpackage

`default_nettype wire

/* hw/rtl/lcg_random_range_generator.sv */
// lcg_random_range_generator: 31-bit linear congruential generator with
// range and modulo reduction.
// input channel: in_valid_i / in_stall_o with mode_i, range_low_i,
//   range_high_i, modulus_i and new_seed_i; a word is taken when valid is
//   high and stall is low. mode 0 raw draw, 1 signed inclusive range,
//   2 unsigned modulo, 3 seed load.
// output channel: out_valid_o / out_stall_i with result_value_o and
//   error_flag_o, one result word per input word, in order.
// sequence: a range or modulo word is captured while idle, then passes
//   through one seed update in the multiplier, 31 steps of the radix-2
//   remainder unit and a finish state that registers the result; raw
//   draws, seed loads and words with an empty range or zero modulus skip
//   the divider. the next word is taken once the result is registered.
// a finished result sits in the output register, so the next input word is
//   taken while the receiver stalls; a second result waits in the controller
//   until the register is free, and input stall stays high meanwhile.
// reset clears the seed to zero and drops both valid paths.
`default_nettype none

module lcg_random_range_generator
  import lcg_rng_pkg::*;
(
  input  wire  logic                     clk_i,
  input  wire  logic                     rst_ni,
  input  wire  logic                     in_valid_i,
  output logic                           in_stall_o,
  input  wire  logic [1:0]               mode_i,
  input  wire  logic signed [WORD_W-1:0] range_low_i,
  input  wire  logic signed [WORD_W-1:0] range_high_i,
  input  wire  logic [WORD_W-1:0]        modulus_i,
  input  wire  logic [SEED_W-1:0]        new_seed_i,
  output logic                           out_valid_o,
  input  wire  logic                     out_stall_i,
  output logic signed [WORD_W-1:0]       result_value_o,
  output logic                           error_flag_o
);

  cmd_t cmd;
  sts_t sts;

  lcg_rng_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lcg_rng_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .mode_i         (mode_i),
    .range_low_i    (range_low_i),
    .range_high_i   (range_high_i),
    .modulus_i      (modulus_i),
    .new_seed_i     (new_seed_i),
    .result_value_o (result_value_o),
    .error_flag_o   (error_flag_o)
  );

endmodule

`default_nettype wire

/* hw/rtl/lcg_rng_ctrl.sv */
`default_nettype none

module lcg_rng_ctrl
  import lcg_rng_pkg::*;
(
  input  wire  logic clk_i,
  input  wire  logic rst_ni,
  input  wire  logic in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  wire  logic out_stall_i,
  input  wire  sts_t sts_i,
  output cmd_t       cmd_o
);

  state_e               state_q, state_d;
  logic [DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;
  logic                 out_valid_q, out_valid_d;
  logic                 slot_free;
  logic                 div_last;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign div_last  = (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DRAW;
      end
      ST_DRAW: begin
        state_d = sts_i.need_div ? ST_DIVIDE : ST_FINISH;
      end
      ST_DIVIDE: begin
        if (div_last) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.capture  = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.advance  = (state_q == ST_DRAW);
    cmd_o.div_step = (state_q == ST_DIVIDE);
    cmd_o.finish   = (state_q == ST_FINISH) && slot_free;
    in_stall_o     = (state_q != ST_IDLE);
  end

  always_comb begin
    div_cnt_d = div_cnt_q;
    if (state_q == ST_DRAW) begin
      div_cnt_d = '0;
    end else if (state_q == ST_DIVIDE) begin
      div_cnt_d = div_cnt_q + DIV_CNT_W'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // a finished word never overwrites one still held by the receiver
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> !(out_valid_q && out_stall_i))
    else $error("result overwritten while stalled");

  // division always starts from a fresh draw with a cleared step count
  a_div_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIVIDE) && ($past(state_q) != ST_DIVIDE) |->
      ($past(state_q) == ST_DRAW) && (div_cnt_q == '0))
    else $error("divide entered without draw");

  // the step counter never runs past the last quotient bit
  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIVIDE) && div_last |=> (state_q == ST_FINISH))
    else $error("divide overran its step count");

endmodule

`default_nettype wire

/* hw/rtl/lcg_rng_dp.sv */
`default_nettype none

module lcg_rng_dp
  import lcg_rng_pkg::*;
(
  input  wire  logic                     clk_i,
  input  wire  logic                     rst_ni,
  input  wire  cmd_t                     cmd_i,
  output sts_t                           sts_o,
  input  wire  logic [1:0]               mode_i,
  input  wire  logic signed [WORD_W-1:0] range_low_i,
  input  wire  logic signed [WORD_W-1:0] range_high_i,
  input  wire  logic [WORD_W-1:0]        modulus_i,
  input  wire  logic [SEED_W-1:0]        new_seed_i,
  output logic signed [WORD_W-1:0]       result_value_o,
  output logic                           error_flag_o
);

  mode_e               mode_in;
  mode_e               mode_q;
  logic [WORD_W-1:0]   low_q;
  logic [SEED_W-1:0]   new_seed_q;
  logic [SPAN_W-1:0]   divisor_q, divisor_d;
  logic                err_q, err_d;
  logic [SEED_W-1:0]   seed_q;
  logic [SEED_W-1:0]   seed_prod;
  logic [SEED_W-1:0]   seed_next;
  logic [SEED_W-1:0]   dividend_q;
  logic [SPAN_W-1:0]   rem_q;
  logic [SPAN_W:0]     trial;
  logic [SPAN_W:0]     trial_diff;
  logic [SPAN_W-1:0]   span;
  logic [WORD_W-1:0]   value_d;
  logic [WORD_W-1:0]   value_q;
  logic                error_q;

  assign mode_in = mode_e'(mode_i);

  // span formed one bit wider so a full range does not wrap
  assign span = {range_high_i[WORD_W-1], range_high_i}
              - {range_low_i[WORD_W-1], range_low_i} + SPAN_W'(1);

  always_comb begin
    divisor_d = {1'b0, modulus_i};
    err_d     = 1'b0;
    unique case (mode_in)
      MODE_RANGE: begin
        divisor_d = span;
        err_d     = (range_high_i < range_low_i);
      end
      MODE_MOD: begin
        err_d = (modulus_i == '0);
      end
      MODE_RAW, MODE_LOAD: begin
        err_d = 1'b0;
      end
      default: err_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q     <= mode_in;
      low_q      <= range_low_i;
      new_seed_q <= new_seed_i;
      divisor_q  <= divisor_d;
      err_q      <= err_d;
    end
  end

  assign sts_o.need_div = ((mode_q == MODE_RANGE) || (mode_q == MODE_MOD)) && !err_q;

  // seed update, result kept mod 2^31
  assign seed_prod = LCG_MUL * seed_q;
  assign seed_next = seed_prod + LCG_INC;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (cmd_i.advance) begin
      seed_q <= (mode_q == MODE_LOAD) ? new_seed_q : seed_next;
    end
  end

  // restoring divider, one dividend bit per step
  assign trial      = {rem_q, dividend_q[SEED_W-1]};
  assign trial_diff = trial - {1'b0, divisor_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.advance) begin
      dividend_q <= seed_next;
      rem_q      <= '0;
    end else if (cmd_i.div_step) begin
      dividend_q <= {dividend_q[SEED_W-2:0], 1'b0};
      if (!trial_diff[SPAN_W]) begin
        rem_q <= trial_diff[SPAN_W-1:0];
      end else begin
        rem_q <= trial[SPAN_W-1:0];
      end
    end
  end

  always_comb begin
    value_d = '0;
    unique case (mode_q)
      MODE_RAW:   value_d = {1'b0, seed_q};
      MODE_RANGE: value_d = low_q + rem_q[WORD_W-1:0];
      MODE_MOD:   value_d = rem_q[WORD_W-1:0];
      MODE_LOAD:  value_d = '0;
      default:    value_d = '0;
    endcase
    if (err_q) value_d = '0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      value_q <= value_d;
      error_q <= err_q;
    end
  end

  assign result_value_o = $signed(value_q);
  assign error_flag_o   = error_q;

  // partial remainder stays below the divisor through every step
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (rem_q < divisor_q))
    else $error("partial remainder out of range");

endmodule

`default_nettype wire

/* bench/lcg_random_range_generator_tb.sv */
`default_nettype none

module lcg_random_range_generator_tb
  import lcg_rng_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_WORDS   = 1050;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned DRAIN_WAIT  = 40;

  localparam logic signed [WORD_W-1:0] INT_MIN = {1'b1, {(WORD_W-1){1'b0}}};
  localparam logic signed [WORD_W-1:0] INT_MAX = {1'b0, {(WORD_W-1){1'b1}}};

  typedef struct packed {
    logic signed [WORD_W-1:0] value;
    logic                     flag;
  } draw_result_t;

  // predicts each result word from the requests that the block accepts
  class lcg_draw_tracker;
    logic [SEED_W-1:0] seed_state;
    draw_result_t      expected_draws[$];
    int unsigned       mismatches;
    int unsigned       results_checked;

    function new();
      seed_state      = '0;
      mismatches      = 0;
      results_checked = 0;
    endfunction

    function void note_request(mode_e mode, logic signed [WORD_W-1:0] lo,
                               logic signed [WORD_W-1:0] hi, logic [WORD_W-1:0] divisor,
                               logic [SEED_W-1:0] load_seed);
      logic [63:0]   product;
      logic [WORD_W-1:0] draw;
      longint        lo_w;
      longint        hi_w;
      longint        span;
      draw_result_t  res;
      res = '0;
      if (mode == MODE_LOAD) begin
        seed_state = load_seed;
      end else begin
        product    = 64'(LCG_MUL) * 64'(seed_state) + 64'(LCG_INC);
        seed_state = product[SEED_W-1:0];
        draw       = {1'b0, seed_state};
        case (mode)
          MODE_RAW: begin
            res.value = draw;
          end
          MODE_RANGE: begin
            lo_w = lo;
            hi_w = hi;
            if (hi_w < lo_w) begin
              res.flag = 1'b1;
            end else begin
              span      = hi_w - lo_w + 1;
              res.value = WORD_W'(lo_w + longint'(draw) % span);
            end
          end
          default: begin
            if (divisor == '0) begin
              res.flag = 1'b1;
            end else begin
              res.value = draw % divisor;
            end
          end
        endcase
      end
      expected_draws.push_back(res);
    endfunction

    function void check_result(logic signed [WORD_W-1:0] value, logic flag);
      draw_result_t want;
      results_checked++;
      if (expected_draws.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result word value=%0d flag=%0b", $realtime, value, flag);
      end else begin
        want = expected_draws.pop_front();
        if (value !== want.value) begin
          mismatches++;
          $display("%0t: result_value expected %0d actual %0d", $realtime, want.value, value);
        end
        if (flag !== want.flag) begin
          mismatches++;
          $display("%0t: error_flag expected %0b actual %0b", $realtime, want.flag, flag);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_draws.size();
    endfunction
  endclass

  logic                     clk_i          = 1'b0;
  logic                     rst_ni         = 1'b0;
  logic                     in_valid_i     = 1'b0;
  logic                     in_stall_o;
  logic [1:0]               mode_i         = MODE_RAW;
  logic signed [WORD_W-1:0] range_low_i    = '0;
  logic signed [WORD_W-1:0] range_high_i   = '0;
  logic [WORD_W-1:0]        modulus_i      = '0;
  logic [SEED_W-1:0]        new_seed_i     = '0;
  logic                     out_valid_o;
  logic                     out_stall_i    = 1'b0;
  logic signed [WORD_W-1:0] result_value_o;
  logic                     error_flag_o;

  lcg_draw_tracker draws = new();
  int unsigned     cycle_count = 0;

  lcg_random_range_generator i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .mode_i,
    .range_low_i,
    .range_high_i,
    .modulus_i,
    .new_seed_i,
    .out_valid_o,
    .out_stall_i,
    .result_value_o,
    .error_flag_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      draws.check_result(result_value_o, error_flag_o);
    end
  end

  task automatic send_word(mode_e mode, logic signed [WORD_W-1:0] lo,
                           logic signed [WORD_W-1:0] hi, logic [WORD_W-1:0] divisor,
                           logic [SEED_W-1:0] load_seed);
    @(negedge clk_i);
    in_valid_i   = 1'b1;
    mode_i       = mode;
    range_low_i  = lo;
    range_high_i = hi;
    modulus_i    = divisor;
    new_seed_i   = load_seed;
    do @(posedge clk_i); while (in_stall_o);
    draws.note_request(mode, lo, hi, divisor, load_seed);
  endtask

  task automatic idle_cycles(int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
  endtask

  task automatic random_request();
    logic signed [WORD_W-1:0] a;
    logic signed [WORD_W-1:0] b;
    logic signed [WORD_W-1:0] lo;
    logic signed [WORD_W-1:0] hi;
    logic [WORD_W-1:0]        divisor;
    int                       width;
    int unsigned              pick;
    mode_e                    mode;
    a       = $urandom;
    b       = $urandom;
    divisor = $urandom;
    lo      = (a < b) ? a : b;
    hi      = (a < b) ? b : a;
    pick    = $urandom_range(0, 99);
    if (pick < 20) mode = MODE_RAW;
    else if (pick < 55) mode = MODE_RANGE;
    else if (pick < 85) mode = MODE_MOD;
    else mode = MODE_LOAD;
    if (mode == MODE_RANGE) begin
      case ($urandom_range(0, 7))
        0: begin
          // empty range
          if (a == b) begin
            lo = INT_MAX;
            hi = INT_MIN;
          end else begin
            lo = (a < b) ? b : a;
            hi = (a < b) ? a : b;
          end
        end
        1, 2: begin
          width = int'($urandom_range(0, 15));
          if (lo > INT_MAX - width) lo = INT_MAX - width;
          hi = lo + width;
        end
        3: begin
          if ($urandom_range(0, 1)) lo = INT_MIN;
          if ($urandom_range(0, 1)) hi = INT_MAX;
        end
        default: ;
      endcase
    end else if (mode == MODE_MOD) begin
      case ($urandom_range(0, 9))
        0: divisor = '0;
        1, 2: divisor = $urandom_range(1, 16);
        3: divisor = 32'd1 << $urandom_range(0, WORD_W - 1);
        4: divisor = divisor >> $urandom_range(0, WORD_W - 1);
        default: ;
      endcase
    end
    send_word(mode, lo, hi, divisor, SEED_W'($urandom));
  endtask

  // receiver: free stretches, choppy stretches and one long hold
  initial begin
    bit held_off;
    held_off = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held_off && draws.results_checked >= 40) begin
        held_off = 1'b1;
        repeat (LONG_HOLD) begin
          @(negedge clk_i);
          out_stall_i = 1'b1;
        end
      end
      repeat ($urandom_range(0, 30)) begin
        @(negedge clk_i);
        out_stall_i = 1'b0;
      end
      repeat ($urandom_range(1, 20)) begin
        @(negedge clk_i);
        out_stall_i = ($urandom_range(0, 2) == 0);
      end
    end
  end

  initial begin
    int unsigned sent;
    int unsigned burst;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    send_word(MODE_RAW, '0, '0, '0, '0);
    send_word(MODE_LOAD, INT_MIN, INT_MAX, '1, '0);
    send_word(MODE_RAW, INT_MAX, INT_MIN, '0, '1);
    send_word(MODE_LOAD, '0, '0, '0, '1);
    send_word(MODE_RAW, '0, '0, '0, '0);
    send_word(MODE_RANGE, INT_MIN, INT_MAX, '0, '0);
    send_word(MODE_RANGE, 32'sd5, 32'sd5, '0, '0);
    send_word(MODE_RANGE, INT_MIN, INT_MIN, '0, '0);
    send_word(MODE_RANGE, INT_MAX, INT_MAX, '0, '0);
    send_word(MODE_RANGE, 32'sd7, 32'sd6, '0, '0);
    send_word(MODE_RANGE, INT_MAX, INT_MIN, '0, '0);
    send_word(MODE_RANGE, -32'sd10, -32'sd1, '0, '0);
    send_word(MODE_RANGE, INT_MIN, 32'sd0, '1, '1);
    send_word(MODE_RANGE, 32'sd0, INT_MAX, '0, '0);
    send_word(MODE_MOD, '0, '0, '0, '0);
    send_word(MODE_MOD, '0, '0, 32'd1, '0);
    send_word(MODE_MOD, '1, '1, '1, '1);
    send_word(MODE_MOD, '0, '0, 32'h8000_0000, '0);
    send_word(MODE_MOD, '0, '0, 32'd7, '0);
    send_word(MODE_LOAD, '1, '1, '1, 31'h2AAA_AAAA);
    send_word(MODE_RAW, '0, '0, '0, '0);
    sent = 21;

    while (sent < NUM_WORDS) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        random_request();
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 6));
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (draws.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (draws.mismatches == 0 && draws.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
hw/rtl/lcg_rng_pkg.sv
hw/rtl/lcg_rng_ctrl.sv
hw/rtl/lcg_rng_dp.sv
hw/rtl/lcg_random_range_generator.sv
bench/lcg_random_range_generator_tb.sv
